@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/sha_pkg.sv @@
// Package with SHA-256 types, constants and round functions.
`timescale 1ns / 1ps
package sha_pkg;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam logic [7:0]  PadByte    = 8'h80;
    localparam logic [5:0]  LenStart   = 6'd56;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    typedef struct packed {
        logic       start;
        logic       busy;
    } t_core_ctl;

    localparam logic [31:0] RoundK [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] InitH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] csig0(input logic [31:0] x);
        csig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] csig1(input logic [31:0] x);
        csig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction
endpackage

@@ hdl/sha256_stream_hasher.sv @@
// Top level of the SHA-256 stream hasher: byte buffer memory, padding and digest output.
// Requests are taken only while the block is idle. An absorb request writes its byte into
// a 64-byte buffer memory. The byte that fills the buffer starts a compression: the buffer
// is read into the block register, the core runs its 64 rounds, and then it completes. The
// block stalls for all of it. A finish request writes the padding and length through the
// memory, byte by byte from the buffered count to the end of the block, and then compresses.
// When more than 55 bytes were buffered, a second padding pass over the whole block and a
// second compression follow. The eight digest words then go out one per accepted cycle, and
// the wait state restores the initial hash before the next request is taken. No new byte is
// taken while the buffer is loaded or a block is compressed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_stream_hasher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sha_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output sha_pkg::t_out o_data
);
    import sha_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_COMP  = 6'b000100,
        S_PAD   = 6'b001000,
        S_OUT   = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    t_state       r_state, n_state;
    logic [7:0]   r_mem [0:BlockBytes-1];
    logic [511:0] r_block;
    logic [5:0]   r_count, n_count;
    logic [63:0]  r_msg, n_msg;
    logic [255:0] r_hash;
    logic [5:0]   r_ptr;
    logic [6:0]   r_load;
    logic         r_final;
    logic         r_extra;
    logic [2:0]   r_oidx;
    logic [63:0]  r_bits;
    logic         wr_en;
    logic [5:0]   wr_addr;
    logic [7:0]   wr_data;
    logic [7:0]   rd_data;
    logic         core_start, core_done, core_busy;
    logic [255:0] core_hash;
    logic         accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        rd_data <= r_mem[r_load[5:0]];
    end

    // Absorb byte at r_count or padding byte at r_ptr; pad block is final unless the marker spills over.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count;
        wr_data = i_data.data_byte;
        if (accept && i_data.command == CMD_ABSORB) begin
            wr_en = 1'b1;
        end else if (r_state == S_PAD) begin
            wr_en   = 1'b1;
            wr_addr = r_ptr;
            if (r_ptr == r_count && (r_extra || r_count < LenStart)) begin
                wr_data = PadByte;
            end else if (r_ptr >= LenStart && !r_extra) begin
                wr_data = r_bits[8 * (7 - (r_ptr - LenStart)) +: 8];
            end else begin
                wr_data = 8'h00;
            end
        end
    end

    assign core_start = (r_state == S_LOAD) && (r_load == 7'd65);

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_block (r_block),
        .i_hash  (r_hash),
        .o_hash  (core_hash),
        .o_done  (core_done),
        .o_busy  (core_busy)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_msg   = r_msg;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_data.command == CMD_ABSORB) begin
                        n_count = r_count + 6'd1;
                        n_msg   = r_msg + 64'd1;
                        if (r_count == 6'(BlockBytes - 1)) begin
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_ptr == 6'(BlockBytes - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_load == 7'd65) begin
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                if (core_done) begin
                    if (!r_final) begin
                        n_state = S_IDLE;
                    end else if (r_extra) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!i_stall && r_oidx == 3'd7) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_IDLE;
                n_count = '0;
                n_msg   = '0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_msg   <= '0;
            r_ptr   <= '0;
            r_load  <= '0;
            r_final <= 1'b0;
            r_extra <= 1'b0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[255 - 32 * i -: 32] <= InitH[i];
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_msg   <= n_msg;
            if (r_state == S_IDLE && accept && i_data.command == CMD_FINISH) begin
                r_final <= 1'b1;
                r_extra <= (r_count > 6'd55);
                r_bits  <= {r_msg[60:0], 3'b000};
                r_ptr   <= r_count;
            end
            if (r_state == S_IDLE && n_state == S_LOAD) begin
                r_final <= 1'b0;
                r_load  <= '0;
            end
            if (r_state == S_PAD) begin
                r_ptr <= r_ptr + 6'd1;
                if (r_ptr == 6'(BlockBytes - 1)) begin
                    r_load <= '0;
                end
            end
            if (r_state == S_LOAD) begin
                r_load <= r_load + 7'd1;
            end
            if (r_state == S_COMP && core_done) begin
                r_hash <= core_hash;
                if (r_final && r_extra) begin
                    r_extra <= 1'b0;
                    r_ptr   <= '0;
                end
                r_oidx <= '0;
            end
            if (r_state == S_OUT && !i_stall) begin
                r_oidx <= r_oidx + 3'd1;
            end
            if (r_state == S_WAIT) begin
                r_final <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    r_hash[255 - 32 * i -: 32] <= InitH[i];
                end
            end
        end
    end

    // Read data is registered and arrives in the cycle after its address; r_load values 1..64 capture bytes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && r_load != 7'd0 && r_load <= 7'd64) begin
            r_block <= {r_block[503:0], rd_data};
        end
    end

    assign o_valid            = (r_state == S_OUT);
    assign o_data.digest_word = r_hash[255 - 32 * r_oidx -: 32];
    assign o_data.word_index  = r_oidx;
    assign o_data.last_word   = (r_oidx == 3'd7);

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, core_busy, o_stall, "request taken during compression")
    `ASSERT_IMPL(a_out_final, i_clk, i_rst_n, o_valid, r_final && !r_extra, "digest shown before final block")
    `ASSERT_NEXT(a_clear_after_out, i_clk, i_rst_n, r_state == S_WAIT, r_count == 6'd0 && r_msg == 64'd0, "counts not cleared after digest")
endmodule

@@ hdl/sha_core.sv @@
// Compression core: message schedule window and 64 rounds, one per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [511:0]            i_block,
    input  logic [255:0]            i_hash,
    output logic [255:0]            o_hash,
    output logic                    o_done,
    output logic                    o_busy
);
    import sha_pkg::*;

    logic         r_busy, n_busy;
    logic [5:0]   r_round, n_round;
    logic [31:0]  r_w [0:15];
    logic [31:0]  r_v [0:7];
    logic [255:0] r_base;
    logic         r_done;
    logic [31:0]  w_new, t1, t2, w_cur;

    assign w_cur = r_w[0];
    assign w_new = sig1(r_w[14]) + r_w[9] + sig0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + csig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + RoundK[r_round] + w_cur;
    assign t2 = csig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2])
              ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_busy  = r_busy;
        n_round = r_round;
        if (i_start && !r_busy) begin
            n_busy  = 1'b1;
            n_round = '0;
        end else if (r_busy) begin
            n_round = r_round + 6'd1;
            if (r_round == 6'(Rounds - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_round <= n_round;
            r_done  <= r_busy && (r_round == 6'(Rounds - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511 - 32 * i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= i_hash[255 - 32 * i -: 32];
            end
            r_base <= i_hash;
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_hash[255 - 32 * i -: 32] = r_base[255 - 32 * i -: 32] + r_v[i];
        end
    end

    assign o_done = r_done;
    assign o_busy = r_busy;

    `ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, r_busy && r_round == 6'd63, r_done && !r_busy, "done must follow the last round")
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "core busy while done")
endmodule
